[sv/fae_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// fae_pkg
// Shared constants, types and decode tables of the four-register ALU
// executor.
// ---------------------------------------------------------------------------
package fae_pkg;

    localparam int NUM_REGS    = 4;
    localparam int WORD_BITS   = 32;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int FIELD_W     = 32;
    localparam int OPC_W       = 4;
    localparam int NUM_OPS     = 16;
    localparam int MAP_W       = NUM_OPS * OPC_W;
    localparam logic [MAP_W-1:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_FIELDS_W = OPC_W + 3 * FIELD_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 32;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    typedef enum logic [OPC_W-1:0] {
        OP_ADDR, OP_ADDI, OP_MULR, OP_MULI,
        OP_BANR, OP_BANI, OP_BORR, OP_BORI,
        OP_SETR, OP_SETI, OP_GTIR, OP_GTRI,
        OP_GTRR, OP_EQIR, OP_EQRI, OP_EQRR
    } t_op;

    // bit i set: internal operation i reads that operand as a register
    localparam logic [NUM_OPS-1:0] READS_A_REG = 16'hD9FF;
    localparam logic [NUM_OPS-1:0] READS_B_REG = 16'hB455;

    typedef struct packed {
        t_op      op;
        t_reg_idx a_idx;
        t_reg_idx b_idx;
        t_reg_idx d_idx;
        t_word    imm_a;
        t_word    imm_b;
        logic     ok;
    } t_instr;

    function automatic logic is_reg_index(input logic [FIELD_W-1:0] v);
        return v < FIELD_W'(NUM_REGS);
    endfunction

    function automatic t_word to_word(input logic signed [FIELD_W-1:0] v);
        return WORD_BITS'(v);
    endfunction

endpackage
`default_nettype wire

[sv/four_register_alu_executor.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// four_register_alu_executor
// Four-entry register machine with sixteen remappable ALU operations.
//
// Channel   Direction  Payload (low bit first)
// s_axis    in         tdata: opcode[3:0], operand_a, operand_b, dest_index
// m_axis    out        tdata: reg_zero; tuser: executed
// cfg       in         data: opcode_map (64 bits)
//
// One transaction per cycle if m_axis is ready; queue, then output register.
// The register file is read, updated and reported by the back stage in the
// same cycle, so consecutive instructions see each other's writes.
// Reset zeroes the register file and loads the identity opcode map.
// A two-entry queue decouples input acceptance from a stalled result.
// ---------------------------------------------------------------------------
module four_register_alu_executor (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // opcode, operand_a, operand_b, dest_index, zero pad
    input  wire logic [fae_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // reg_zero
    output logic [fae_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // executed
    output logic                                  m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fae_pkg::MAP_W-1:0]        i_cfg_data
);

    fae_pkg::t_instr front_instr;
    fae_pkg::t_instr queue_instr;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_valid;

    fae_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_instr      (front_instr)
    );

    fae_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_instr (front_instr),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_instr (queue_instr)
    );

    fae_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .o_pop      (pop),
        .i_instr    (queue_instr),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_reg_zero (m_axis_tdata),
        .o_executed (m_axis_tuser)
    );

endmodule
`default_nettype wire

[sv/fae_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// fae_front
// Accepts instruction transactions, remaps the opcode, checks register
// indexes and pushes decoded instructions into the queue.
// ---------------------------------------------------------------------------
module fae_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fae_pkg::MAP_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [fae_pkg::IN_TDATA_W-1:0] i_data,
    input  wire logic                          i_queue_full,
    output logic                               o_push,
    output fae_pkg::t_instr                    o_instr
);

    logic [fae_pkg::MAP_W-1:0]   r_map;
    logic [fae_pkg::OPC_W-1:0]   opcode;
    logic [fae_pkg::FIELD_W-1:0] opnd_a;
    logic [fae_pkg::FIELD_W-1:0] opnd_b;
    logic [fae_pkg::FIELD_W-1:0] dest;
    fae_pkg::t_op                op;
    logic                        ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= fae_pkg::MAP_RESET;
        end else if (i_cfg_valid) begin
            r_map <= i_cfg_data;
        end
    end

    always_comb begin
        opcode = i_data[fae_pkg::OPC_W-1:0];
        opnd_a = i_data[fae_pkg::OPC_W +: fae_pkg::FIELD_W];
        opnd_b = i_data[fae_pkg::OPC_W + fae_pkg::FIELD_W +: fae_pkg::FIELD_W];
        dest   = i_data[fae_pkg::OPC_W + 2 * fae_pkg::FIELD_W +: fae_pkg::FIELD_W];
        op     = fae_pkg::t_op'(r_map[{opcode, 2'b00} +: fae_pkg::OPC_W]);
        ok     = fae_pkg::is_reg_index(dest)
                 && (!fae_pkg::READS_A_REG[op] || fae_pkg::is_reg_index(opnd_a))
                 && (!fae_pkg::READS_B_REG[op] || fae_pkg::is_reg_index(opnd_b));

        o_instr.op    = op;
        o_instr.a_idx = opnd_a[fae_pkg::REG_IDX_W-1:0];
        o_instr.b_idx = opnd_b[fae_pkg::REG_IDX_W-1:0];
        o_instr.d_idx = dest[fae_pkg::REG_IDX_W-1:0];
        o_instr.imm_a = fae_pkg::to_word(opnd_a);
        o_instr.imm_b = fae_pkg::to_word(opnd_b);
        o_instr.ok    = ok;
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

endmodule
`default_nettype wire

[sv/fae_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// fae_queue
// Short queue of decoded instructions between front and back.
// ---------------------------------------------------------------------------
module fae_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fae_pkg::t_instr i_instr,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output fae_pkg::t_instr      o_instr
);

    fae_pkg::t_instr              r_slot [fae_pkg::QUEUE_DEPTH];
    logic [fae_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [fae_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [fae_pkg::QCNT_W-1:0]   r_count;
    logic [fae_pkg::QPTR_W-1:0]   n_wr_ptr;
    logic [fae_pkg::QPTR_W-1:0]   n_rd_ptr;
    logic [fae_pkg::QCNT_W-1:0]   n_count;

    assign o_full  = r_count == fae_pkg::QCNT_W'(fae_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_instr = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == fae_pkg::QPTR_W'(fae_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == fae_pkg::QPTR_W'(fae_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_instr;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fae_pkg::QCNT_W'(fae_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

[sv/fae_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// fae_back
// Executes decoded instructions on the register file and registers the
// result transaction.
// ---------------------------------------------------------------------------
module fae_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_pop,
    input  wire fae_pkg::t_instr                i_instr,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [fae_pkg::OUT_TDATA_W-1:0]     o_reg_zero,
    output logic                                o_executed
);

    fae_pkg::t_word r_rf [fae_pkg::NUM_REGS];
    logic           r_out_valid;
    logic [fae_pkg::OUT_TDATA_W-1:0] r_reg_zero;
    logic           r_executed;

    fae_pkg::t_word va;
    fae_pkg::t_word vb;
    fae_pkg::t_word mul_b;
    fae_pkg::t_word prod;
    fae_pkg::t_word res;
    fae_pkg::t_word n_zero;
    logic           gt_ia_vb;
    logic           gt_va_ib;
    logic           gt_va_vb;
    logic           eq_ia_vb;
    logic           eq_va_ib;
    logic           eq_va_vb;
    logic           write_en;

    assign o_pop = i_valid && (!r_out_valid || i_ready);

    always_comb begin
        va       = r_rf[i_instr.a_idx];
        vb       = r_rf[i_instr.b_idx];
        mul_b    = (i_instr.op == fae_pkg::OP_MULR) ? vb : i_instr.imm_b;
        prod     = va * mul_b;
        gt_ia_vb = $signed(i_instr.imm_a) > $signed(vb);
        gt_va_ib = $signed(va) > $signed(i_instr.imm_b);
        gt_va_vb = $signed(va) > $signed(vb);
        eq_ia_vb = i_instr.imm_a == vb;
        eq_va_ib = va == i_instr.imm_b;
        eq_va_vb = va == vb;
        case (i_instr.op)
            fae_pkg::OP_ADDR: res = va + vb;
            fae_pkg::OP_ADDI: res = va + i_instr.imm_b;
            fae_pkg::OP_MULR: res = prod;
            fae_pkg::OP_MULI: res = prod;
            fae_pkg::OP_BANR: res = va & vb;
            fae_pkg::OP_BANI: res = va & i_instr.imm_b;
            fae_pkg::OP_BORR: res = va | vb;
            fae_pkg::OP_BORI: res = va | i_instr.imm_b;
            fae_pkg::OP_SETR: res = va;
            fae_pkg::OP_SETI: res = i_instr.imm_a;
            fae_pkg::OP_GTIR: res = fae_pkg::WORD_BITS'(gt_ia_vb);
            fae_pkg::OP_GTRI: res = fae_pkg::WORD_BITS'(gt_va_ib);
            fae_pkg::OP_GTRR: res = fae_pkg::WORD_BITS'(gt_va_vb);
            fae_pkg::OP_EQIR: res = fae_pkg::WORD_BITS'(eq_ia_vb);
            fae_pkg::OP_EQRI: res = fae_pkg::WORD_BITS'(eq_va_ib);
            fae_pkg::OP_EQRR: res = fae_pkg::WORD_BITS'(eq_va_vb);
            default:          res = '0;
        endcase
        write_en = o_pop && i_instr.ok;
        n_zero   = (i_instr.ok && i_instr.d_idx == '0) ? res : r_rf[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fae_pkg::NUM_REGS; i++) begin
                r_rf[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (write_en) begin
                r_rf[i_instr.d_idx] <= res;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_reg_zero <= fae_pkg::OUT_TDATA_W'(n_zero);
            r_executed <= i_instr.ok;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_reg_zero = r_reg_zero;
    assign o_executed = r_executed;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_rf[0]) && $stable(r_reg_zero))
        else $error("register state moved while result stalled");

    a_zero_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_pop) |-> r_reg_zero == fae_pkg::OUT_TDATA_W'(r_rf[0]))
        else $error("reported register zero differs from register file");

    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_instr.ok) |=> $stable(r_rf[0]))
        else $error("rejected instruction changed register zero");

endmodule
`default_nettype wire
